/* src/wf2d_pkg.sv */
// ----------------------------------------------------------------------------
// wf2d_pkg
// Shared types, constants and helpers for the 2D wave field step core.
// ----------------------------------------------------------------------------
`default_nettype none

package wf2d_pkg;

    localparam int GRID_SIDE = 32;
    localparam int IDX_W     = $clog2(GRID_SIDE);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int EVEN_SIDE = GRID_SIDE - (GRID_SIDE % 2);
    localparam int N_W       = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [16:0] FACTOR_ONE = 17'd65536;
    localparam logic [16:0] FACTOR_MAX = 17'd131071;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_SIZE     = 3'd0,
        CFG_FORCE_GAIN      = 3'd1,
        CFG_STEP_TIME       = 3'd2,
        CFG_PRESSURE_RETAIN = 3'd3,
        CFG_VELOCITY_RETAIN = 3'd4,
        CFG_DEPOSIT_LIMIT   = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_STEP   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_ADD    = 3'd2,
        OP_READ   = 3'd3,
        OP_SAMPLE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ARR_PRESSURE = 2'd0,
        ARR_VELOCITY = 2'd1,
        ARR_FACTOR   = 2'd2,
        ARR_DEPOSIT  = 2'd3
    } arr_t;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_BAD,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7,
        ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5,
        ST_RD0, ST_RD1, ST_WR, ST_AD0, ST_AD1,
        ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8,
        ST_DONE
    } state_t;

    typedef enum logic [5:0] {
        UOP_NONE, UOP_CLEAR, UOP_CAPTURE, UOP_BAD,
        UOP_F0, UOP_F1, UOP_F2, UOP_F3, UOP_F4, UOP_F5, UOP_F6, UOP_F7,
        UOP_U0, UOP_U1, UOP_U2, UOP_U3, UOP_U4, UOP_U5,
        UOP_RD0, UOP_RD1, UOP_WR, UOP_AD0, UOP_AD1,
        UOP_S0, UOP_S1, UOP_S2, UOP_S3, UOP_S4, UOP_S5, UOP_S6, UOP_S7, UOP_S8,
        UOP_PUBLISH
    } uop_t;

    typedef struct packed {
        uop_t uop;
        logic cnt_clear;
        logic cnt_next;
        logic full_range;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       index_bad;
        logic       last_cell;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        logic signed [31:0] n;
        n = -x;
        return x[31] ? n : x;
    endfunction

endpackage

`default_nettype wire

/* src/wf2d_ctrl.sv */
// ----------------------------------------------------------------------------
// wf2d_ctrl
// Sequencer: walks each operation through its micro steps and owns the
// handshakes of the item and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wf2d_ctrl
    import wf2d_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    output logic         result_valid,
    input  wire logic    result_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   publish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.uop        = UOP_NONE;
        cmd.cnt_clear  = 1'b0;
        cmd.cnt_next   = 1'b0;
        cmd.full_range = 1'b0;
        publish        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.uop        = UOP_CLEAR;
                cmd.full_range = 1'b1;
                if (status.last_cell)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                    cmd.cnt_next = 1'b1;
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.uop    = UOP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.cnt_clear = 1'b1;
                if (status.op == OP_STEP)
                    state_next = ST_F0;
                else if (status.op > OP_SAMPLE)
                    state_next = ST_DONE;
                else if (status.index_bad)
                    state_next = ST_BAD;
                else
                begin
                    case (status.op)
                        OP_WRITE:  state_next = ST_WR;
                        OP_ADD:    state_next = ST_AD0;
                        OP_READ:   state_next = ST_RD0;
                        default:   state_next = ST_S0;
                    endcase
                end
            end
            ST_BAD:  begin cmd.uop = UOP_BAD;  state_next = ST_DONE; end
            ST_F0:   begin cmd.uop = UOP_F0;   state_next = ST_F1;   end
            ST_F1:   begin cmd.uop = UOP_F1;   state_next = ST_F2;   end
            ST_F2:   begin cmd.uop = UOP_F2;   state_next = ST_F3;   end
            ST_F3:   begin cmd.uop = UOP_F3;   state_next = ST_F4;   end
            ST_F4:   begin cmd.uop = UOP_F4;   state_next = ST_F5;   end
            ST_F5:   begin cmd.uop = UOP_F5;   state_next = ST_F6;   end
            ST_F6:   begin cmd.uop = UOP_F6;   state_next = ST_F7;   end
            ST_F7:
            begin
                cmd.uop = UOP_F7;
                if (status.last_cell)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_U0;
                end
                else
                begin
                    cmd.cnt_next = 1'b1;
                    state_next   = ST_F0;
                end
            end
            ST_U0:   begin cmd.uop = UOP_U0;   state_next = ST_U1;   end
            ST_U1:   begin cmd.uop = UOP_U1;   state_next = ST_U2;   end
            ST_U2:   begin cmd.uop = UOP_U2;   state_next = ST_U3;   end
            ST_U3:   begin cmd.uop = UOP_U3;   state_next = ST_U4;   end
            ST_U4:   begin cmd.uop = UOP_U4;   state_next = ST_U5;   end
            ST_U5:
            begin
                cmd.uop = UOP_U5;
                if (status.last_cell)
                    state_next = ST_DONE;
                else
                begin
                    cmd.cnt_next = 1'b1;
                    state_next   = ST_U0;
                end
            end
            ST_RD0:  begin cmd.uop = UOP_RD0;  state_next = ST_RD1;  end
            ST_RD1:  begin cmd.uop = UOP_RD1;  state_next = ST_DONE; end
            ST_WR:   begin cmd.uop = UOP_WR;   state_next = ST_DONE; end
            ST_AD0:  begin cmd.uop = UOP_AD0;  state_next = ST_AD1;  end
            ST_AD1:  begin cmd.uop = UOP_AD1;  state_next = ST_DONE; end
            ST_S0:   begin cmd.uop = UOP_S0;   state_next = ST_S1;   end
            ST_S1:   begin cmd.uop = UOP_S1;   state_next = ST_S2;   end
            ST_S2:   begin cmd.uop = UOP_S2;   state_next = ST_S3;   end
            ST_S3:   begin cmd.uop = UOP_S3;   state_next = ST_S4;   end
            ST_S4:   begin cmd.uop = UOP_S4;   state_next = ST_S5;   end
            ST_S5:   begin cmd.uop = UOP_S5;   state_next = ST_S6;   end
            ST_S6:   begin cmd.uop = UOP_S6;   state_next = ST_S7;   end
            ST_S7:   begin cmd.uop = UOP_S7;   state_next = ST_S8;   end
            ST_S8:   begin cmd.uop = UOP_S8;   state_next = ST_DONE; end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.uop    = UOP_PUBLISH;
                    publish    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (publish)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

/* src/wf2d_dp.sv */
// ----------------------------------------------------------------------------
// wf2d_dp
// Datapath: configuration registers, grid memories, cell counters, the
// shared multiplier and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wf2d_dp
    import wf2d_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [2:0]            operation,
    input  wire logic [4:0]            row,
    input  wire logic [4:0]            col,
    input  wire logic [1:0]            which_array,
    input  wire logic signed [31:0]    value,
    input  wire logic [15:0]           row_fraction,
    input  wire logic [15:0]           col_fraction,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic signed [31:0]         result_value,
    output logic                       index_error
);

    // configuration
    logic [5:0]  active_size_reg;
    logic [31:0] force_gain_reg;
    logic [31:0] step_time_reg;
    logic [16:0] pressure_retain_reg;
    logic [16:0] velocity_retain_reg;
    logic [30:0] deposit_limit_reg;

    // captured item
    logic [2:0]         op_q;
    logic [4:0]         row_q;
    logic [4:0]         col_q;
    logic [1:0]         arr_q;
    logic signed [31:0] val_q;
    logic [15:0]        rf_q;
    logic [15:0]        cf_q;

    // cell counters
    logic [IDX_W-1:0] row_cnt_reg, row_cnt_next;
    logic [IDX_W-1:0] col_cnt_reg, col_cnt_next;

    // memories
    logic signed [31:0] pmem [CELLS];
    logic signed [31:0] vmem [CELLS];
    logic [16:0]        fmem [CELLS];
    logic signed [31:0] dmem [CELLS];

    logic [ADDR_W-1:0]  p_addr_a, p_addr_b, v_addr, f_addr, d_addr;
    logic               p_re, p_we, v_re, v_we, f_re, f_we, d_re, d_we;
    logic signed [31:0] p_wdata, v_wdata, d_wdata;
    logic [16:0]        f_wdata;
    logic signed [31:0] p_qa, p_qb, v_q, d_q;
    logic [16:0]        f_q;

    // arithmetic registers
    logic [67:0]        prod_reg;
    logic               mul_neg_reg;
    logic signed [34:0] acc_reg;
    logic               lap_neg_reg;
    logic [34:0]        lap_mag_reg;
    logic [34:0]        hip_reg;
    logic [51:0]        t_reg;
    logic [32:0]        lowp_reg;
    logic signed [31:0] cl_reg;
    logic signed [32:0] pp_reg;
    logic signed [34:0] sum_reg;
    logic signed [31:0] ha_reg, hb_reg, hc_reg, hd_reg;
    logic signed [49:0] bacc_reg;
    logic signed [31:0] res_reg;
    logic               err_reg;
    logic signed [31:0] result_value_reg;
    logic               index_error_reg;

    // combinational
    logic [N_W-1:0]     side;
    logic [IDX_W-1:0]   nm1, lim_m1;
    logic [IDX_W-1:0]   row_i, col_i, r2, c2;
    logic [IDX_W-1:0]   up_i, dn_i, lf_i, rt_i;
    logic [ADDR_W-1:0]  cell_addr, item_cell;
    logic [35:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_n;
    logic signed [35:0] lap;
    logic               lap_neg;
    logic [34:0]        lap_mag;
    logic signed [68:0] prod_s;
    logic signed [52:0] prod_tz16;
    logic [67:0]        q;
    logic [33:0]        q_c;
    logic signed [34:0] force_add;
    logic signed [31:0] vel_force;
    logic signed [31:0] lim_s;
    logic signed [31:0] clip;
    logic signed [33:0] vv;
    logic signed [50:0] blend_sum;
    logic signed [34:0] blend_out;
    logic [16:0]        w_row0, w_col0;
    logic [16:0]        factor_wr;
    logic signed [31:0] read_sel;

    always_comb
    begin
        side = active_size_reg & 6'h3E;
        if (side < 6'd2)
            side = 6'd2;
        if (int'(side) > EVEN_SIDE)
            side = N_W'(EVEN_SIDE);
    end

    assign nm1    = IDX_W'(side - 6'd1);
    assign lim_m1 = cmd.full_range ? IDX_W'(GRID_SIDE - 1) : nm1;
    assign row_i  = IDX_W'(row_q);
    assign col_i  = IDX_W'(col_q);
    assign r2     = (row_i == nm1) ? '0 : IDX_W'(row_i + 1'b1);
    assign c2     = (col_i == nm1) ? '0 : IDX_W'(col_i + 1'b1);
    assign up_i   = (row_cnt_reg == '0) ? nm1 : IDX_W'(row_cnt_reg - 1'b1);
    assign dn_i   = (row_cnt_reg == nm1) ? '0 : IDX_W'(row_cnt_reg + 1'b1);
    assign lf_i   = (col_cnt_reg == '0) ? nm1 : IDX_W'(col_cnt_reg - 1'b1);
    assign rt_i   = (col_cnt_reg == nm1) ? '0 : IDX_W'(col_cnt_reg + 1'b1);
    assign cell_addr = {row_cnt_reg, col_cnt_reg};
    assign item_cell = {row_i, col_i};

    assign status.op        = op_q;
    assign status.index_bad = ({1'b0, row_q} >= side) || ({1'b0, col_q} >= side);
    assign status.last_cell = (row_cnt_reg == lim_m1) && (col_cnt_reg == lim_m1);

    // force arithmetic
    assign lap       = 36'(acc_reg) - (36'(p_qa) <<< 2);
    assign lap_neg   = lap[35];
    assign lap_mag   = 35'(lap_neg ? -lap : lap);
    assign prod_s    = mul_neg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    assign prod_tz16 = mul_neg_reg ? -$signed({1'b0, prod_reg[67:16]})
                                   : $signed({1'b0, prod_reg[67:16]});
    assign q         = prod_reg + 68'(lowp_reg[32:16]);
    assign q_c       = (q > 68'h2_0000_0000) ? 34'h2_0000_0000 : q[33:0];
    assign force_add = lap_neg_reg ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
    assign vel_force = sat32(64'(v_q) + 64'(force_add));

    // update arithmetic
    assign lim_s = $signed({1'b0, deposit_limit_reg});
    assign clip  = (d_q < lim_s) ? d_q : lim_s;
    assign vv    = 34'(prod_tz16);

    // sample arithmetic
    assign w_row0    = 17'(FACTOR_ONE - 17'(rf_q));
    assign w_col0    = 17'(FACTOR_ONE - 17'(cf_q));
    assign blend_sum = 51'(bacc_reg) + 51'(prod_s);
    assign blend_out = 35'(blend_sum >>> 16);

    always_comb
    begin
        if (val_q < 0)
            factor_wr = '0;
        else if (val_q > $signed({15'd0, FACTOR_MAX}))
            factor_wr = FACTOR_MAX;
        else
            factor_wr = val_q[16:0];
    end

    always_comb
    begin
        case (arr_t'(arr_q))
            ARR_PRESSURE: read_sel = p_qa;
            ARR_VELOCITY: read_sel = v_q;
            ARR_FACTOR:   read_sel = $signed({15'd0, f_q});
            default:      read_sel = d_q;
        endcase
    end

    // memory control and multiplier operands
    always_comb
    begin
        p_addr_a = cell_addr;
        p_addr_b = cell_addr;
        v_addr   = cell_addr;
        f_addr   = cell_addr;
        d_addr   = cell_addr;
        p_re = 1'b0; p_we = 1'b0; v_re = 1'b0; v_we = 1'b0;
        f_re = 1'b0; f_we = 1'b0; d_re = 1'b0; d_we = 1'b0;
        p_wdata = '0;
        v_wdata = '0;
        f_wdata = FACTOR_ONE;
        d_wdata = '0;
        mul_a = '0;
        mul_b = '0;
        mul_n = 1'b0;
        case (cmd.uop)
            UOP_CLEAR:
            begin
                p_we = 1'b1; v_we = 1'b1; f_we = 1'b1; d_we = 1'b1;
            end
            UOP_F0:
            begin
                p_re = 1'b1;
                p_addr_a = {up_i, col_cnt_reg};
                p_addr_b = {dn_i, col_cnt_reg};
            end
            UOP_F1:
            begin
                p_re = 1'b1;
                p_addr_a = {row_cnt_reg, lf_i};
                p_addr_b = {row_cnt_reg, rt_i};
            end
            UOP_F2:
            begin
                p_re = 1'b1; v_re = 1'b1; f_re = 1'b1;
            end
            UOP_F4:
            begin
                mul_a = 36'(lap_mag_reg[31:0]);
                mul_b = force_gain_reg;
            end
            UOP_F6:
            begin
                mul_a = t_reg[51:16];
                mul_b = 32'(f_q);
            end
            UOP_F7:
            begin
                v_we    = 1'b1;
                v_wdata = vel_force;
            end
            UOP_U0:
            begin
                p_re = 1'b1; v_re = 1'b1; f_re = 1'b1; d_re = 1'b1;
            end
            UOP_U1:
            begin
                mul_a   = 36'(abs32(p_qa));
                mul_b   = 32'(pressure_retain_reg);
                mul_n   = p_qa[31];
                d_we    = 1'b1;
                d_wdata = sat32(64'(d_q) - 64'(clip));
            end
            UOP_U2:
            begin
                mul_a = 36'(abs32(v_q));
                mul_b = step_time_reg;
                mul_n = v_q[31];
            end
            UOP_U3:
            begin
                mul_a = 36'(prod_reg[63:32]);
                mul_b = 32'(f_q);
                mul_n = v_q[31];
            end
            UOP_U4:
            begin
                mul_a = 36'(abs32(v_q));
                mul_b = 32'(velocity_retain_reg);
                mul_n = v_q[31];
            end
            UOP_U5:
            begin
                p_we    = 1'b1;
                p_wdata = sat32(64'(sum_reg));
                v_we    = 1'b1;
                v_wdata = sat32(64'(prod_tz16));
            end
            UOP_RD0:
            begin
                p_addr_a = item_cell; v_addr = item_cell;
                f_addr   = item_cell; d_addr = item_cell;
                p_re = 1'b1; v_re = 1'b1; f_re = 1'b1; d_re = 1'b1;
            end
            UOP_WR:
            begin
                p_addr_a = item_cell; v_addr = item_cell;
                f_addr   = item_cell; d_addr = item_cell;
                p_wdata  = val_q;
                v_wdata  = val_q;
                f_wdata  = factor_wr;
                d_wdata  = val_q;
                case (arr_t'(arr_q))
                    ARR_PRESSURE: p_we = 1'b1;
                    ARR_VELOCITY: v_we = 1'b1;
                    ARR_FACTOR:   f_we = 1'b1;
                    default:      d_we = 1'b1;
                endcase
            end
            UOP_AD0:
            begin
                d_addr = item_cell;
                d_re   = 1'b1;
            end
            UOP_AD1:
            begin
                d_addr  = item_cell;
                d_we    = 1'b1;
                d_wdata = sat32(64'(d_q) + 64'(val_q));
            end
            UOP_S0:
            begin
                p_re = 1'b1;
                p_addr_a = item_cell;
                p_addr_b = {r2, col_i};
            end
            UOP_S1:
            begin
                p_re = 1'b1;
                p_addr_a = {row_i, c2};
                p_addr_b = {r2, c2};
            end
            UOP_S2:
            begin
                mul_a = 36'(abs32(ha_reg));
                mul_b = 32'(w_row0);
                mul_n = ha_reg[31];
            end
            UOP_S3:
            begin
                mul_a = 36'(abs32(hb_reg));
                mul_b = 32'(rf_q);
                mul_n = hb_reg[31];
            end
            UOP_S4:
            begin
                mul_a = 36'(abs32(hc_reg));
                mul_b = 32'(w_row0);
                mul_n = hc_reg[31];
            end
            UOP_S5:
            begin
                mul_a = 36'(abs32(hd_reg));
                mul_b = 32'(rf_q);
                mul_n = hd_reg[31];
            end
            UOP_S6:
            begin
                mul_a = 36'(abs32(ha_reg));
                mul_b = 32'(w_col0);
                mul_n = ha_reg[31];
            end
            UOP_S7:
            begin
                mul_a = 36'(abs32(hb_reg));
                mul_b = 32'(cf_q);
                mul_n = hb_reg[31];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            pmem[p_addr_a] <= p_wdata;
        if (p_re)
        begin
            p_qa <= pmem[p_addr_a];
            p_qb <= pmem[p_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[v_addr] <= v_wdata;
        if (v_re)
            v_q <= vmem[v_addr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
            fmem[f_addr] <= f_wdata;
        if (f_re)
            f_q <= fmem[f_addr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            dmem[d_addr] <= d_wdata;
        if (d_re)
            d_q <= dmem[d_addr];
    end

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (cmd.cnt_clear)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (cmd.cnt_next)
        begin
            if (col_cnt_reg == lim_m1)
            begin
                col_cnt_next = '0;
                row_cnt_next = IDX_W'(row_cnt_reg + 1'b1);
            end
            else
                col_cnt_next = IDX_W'(col_cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg         <= '0;
            col_cnt_reg         <= '0;
            active_size_reg     <= 6'd32;
            force_gain_reg      <= '0;
            step_time_reg       <= '0;
            pressure_retain_reg <= FACTOR_ONE;
            velocity_retain_reg <= FACTOR_ONE;
            deposit_limit_reg   <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ACTIVE_SIZE:     active_size_reg     <= cfg_data[5:0];
                    CFG_FORCE_GAIN:      force_gain_reg      <= cfg_data;
                    CFG_STEP_TIME:       step_time_reg       <= cfg_data;
                    CFG_PRESSURE_RETAIN: pressure_retain_reg <= cfg_data[16:0];
                    CFG_VELOCITY_RETAIN: velocity_retain_reg <= cfg_data[16:0];
                    CFG_DEPOSIT_LIMIT:   deposit_limit_reg   <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= 68'(mul_a * mul_b);
        mul_neg_reg <= mul_n;
        case (cmd.uop)
            UOP_CAPTURE:
            begin
                op_q    <= operation;
                row_q   <= row;
                col_q   <= col;
                arr_q   <= which_array;
                val_q   <= value;
                rf_q    <= row_fraction;
                cf_q    <= col_fraction;
                res_reg <= '0;
                err_reg <= 1'b0;
            end
            UOP_BAD: err_reg <= 1'b1;
            UOP_F1:  acc_reg <= 35'(p_qa) + 35'(p_qb);
            UOP_F2:  acc_reg <= acc_reg + 35'(p_qa) + 35'(p_qb);
            UOP_F3:
            begin
                lap_neg_reg <= lap_neg;
                lap_mag_reg <= lap_mag;
            end
            UOP_F4:  hip_reg  <= 35'(lap_mag_reg[34:32] * force_gain_reg);
            UOP_F5:  t_reg    <= 52'({hip_reg, 16'd0}) + 52'(prod_reg[63:16]);
            UOP_F6:  lowp_reg <= 33'(t_reg[15:0] * f_q);
            UOP_U1:  cl_reg   <= clip;
            UOP_U2:  pp_reg   <= 33'(prod_tz16);
            UOP_U4:  sum_reg  <= 35'(pp_reg) + 35'(vv) + 35'(cl_reg);
            UOP_RD1: res_reg  <= read_sel;
            UOP_S1:
            begin
                ha_reg <= p_qa;
                hb_reg <= p_qb;
            end
            UOP_S2:
            begin
                hc_reg <= p_qa;
                hd_reg <= p_qb;
            end
            UOP_S3, UOP_S5, UOP_S7: bacc_reg <= prod_s[49:0];
            UOP_S4:  ha_reg  <= sat32(64'(blend_out));
            UOP_S6:  hb_reg  <= sat32(64'(blend_out));
            UOP_S8:  res_reg <= sat32(64'(blend_out));
            UOP_PUBLISH:
            begin
                result_value_reg <= res_reg;
                index_error_reg  <= err_reg;
            end
            default: ;
        endcase
    end

    assign result_value = result_value_reg;
    assign index_error  = index_error_reg;

endmodule

`default_nettype wire

/* src/wave_field_2d_step_core.sv */
// ----------------------------------------------------------------------------
// wave_field_2d_step_core
// Damped 2D wave field on a periodic grid: step, cell access and bilinear
// sampling of pressure.
//
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   operation row col which_array
//                                                value row_fraction col_fraction
// result    out        result_valid / result_stall  result_value index_error
// cfg       in         cfg_valid / cfg_ready     cfg_index cfg_data
//
// Step: a force pass and then an update pass over the n*n cells of the size n
// in use; the per-cell work in each pass is set by the single shared multiplier
// and the two read ports of the pressure memory. Write, add, read and sample
// run one transaction at a time. After reset a clearing pass over all
// GRID_SIDE*GRID_SIDE cells (1024) runs with item_stall high. A result waiting
// under result_stall does not block the next item; its completion waits until
// the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wave_field_2d_step_core
    import wf2d_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic [2:0]            operation,
    input  wire logic [4:0]            row,
    input  wire logic [4:0]            col,
    input  wire logic [1:0]            which_array,
    input  wire logic signed [31:0]    value,
    input  wire logic [15:0]           row_fraction,
    input  wire logic [15:0]           col_fraction,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic signed [31:0]         result_value,
    output logic                       index_error,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    wf2d_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    wf2d_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .row          (row),
        .col          (col),
        .which_array  (which_array),
        .value        (value),
        .row_fraction (row_fraction),
        .col_fraction (col_fraction),
        .cmd          (cmd),
        .status       (status),
        .result_value (result_value),
        .index_error  (index_error)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item channel not stalled after a transaction");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && index_error) |-> (result_value == 32'sd0))
        else $error("index error with nonzero result value");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without an item in progress");

endmodule

`default_nettype wire

/* dv/wave_field_2d_step_core_tb.sv */
// ----------------------------------------------------------------------------
// wave_field_2d_step_core_tb
// Self-checking bench for the 2D wave field core. A directed table covers
// reset contents, field extremes, saturation, factor clamping, undefined
// opcodes, wrap-around sampling and index errors. Random phases follow with
// varied register settings and idle/stall patterns. Every result is checked
// against the table's expected value or an in-bench model of the field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wave_field_2d_step_core_tb
    import wf2d_pkg::*;
();

    typedef struct {
        logic [2:0]         op;
        logic [4:0]         r;
        logic [4:0]         c;
        logic [1:0]         arr;
        logic signed [31:0] val;
        logic [15:0]        rf;
        logic [15:0]        cf;
        bit                 typed;
        logic signed [31:0] want_val;
        logic               want_err;
    } row_t;

    typedef struct {
        logic signed [31:0] val;
        logic               err;
    } res_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic [2:0] operation;
    logic [4:0] row;
    logic [4:0] col;
    logic [1:0] which_array;
    logic signed [31:0] value;
    logic [15:0] row_fraction;
    logic [15:0] col_fraction;
    logic result_valid;
    logic result_stall;
    logic signed [31:0] result_value;
    logic index_error;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // side channel that travels with the item
    logic               drv_typed;
    logic signed [31:0] drv_want_val;
    logic               drv_want_err;

    logic signed [31:0] pres [CELLS];
    logic signed [31:0] vel  [CELLS];
    logic signed [31:0] dep  [CELLS];
    logic [16:0]        fac  [CELLS];
    logic [5:0]  m_size;
    logic [31:0] m_gain;
    logic [31:0] m_stime;
    logic [16:0] m_pret;
    logic [16:0] m_vret;
    logic [30:0] m_dlim;

    res_t pending_results[$];
    row_t directed[$];

    int errors;
    int n_items;
    int n_steps;
    int n_results;
    int n_bad_idx;
    int idle_cycles;
    int send_idle_pct;
    int stall_pct;

    wave_field_2d_step_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .row          (row),
        .col          (col),
        .which_array  (which_array),
        .value        (value),
        .row_fraction (row_fraction),
        .col_fraction (col_fraction),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_value (result_value),
        .index_error  (index_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int side_n();
        int s;
        s = int'(m_size & 6'h3E);
        if (s < 2)
            s = 2;
        if (s > EVEN_SIDE)
            s = EVEN_SIDE;
        return s;
    endfunction

    function automatic longint mul_tz(input longint a, input longint unsigned b,
                                      input int sh);
        longint unsigned m;
        longint unsigned p;
        m = (a < 0) ? longint'(-a) : longint'(a);
        p = (m * b) >> sh;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [31:0] sat(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint blend(input longint a, input longint b,
                                     input logic [15:0] t);
        longint s;
        s = a * (65536 - longint'(t)) + b * longint'(t);
        return s >>> 16;
    endfunction

    function automatic void advance_field();
        int n;
        int up, dn, lf, rt, i;
        longint lap, a, v, d, cl, pp, vv;
        longint unsigned mag, hi, lo, t, f, q;
        bit neg;
        n = side_n();
        for (int r = 0; r < n; r++) begin
            up = (r == 0) ? n - 1 : r - 1;
            dn = (r == n - 1) ? 0 : r + 1;
            for (int c = 0; c < n; c++) begin
                lf = (c == 0) ? n - 1 : c - 1;
                rt = (c == n - 1) ? 0 : c + 1;
                i = r * GRID_SIDE + c;
                lap = longint'(pres[up * GRID_SIDE + c]) + longint'(pres[dn * GRID_SIDE + c])
                    + longint'(pres[r * GRID_SIDE + lf]) + longint'(pres[r * GRID_SIDE + rt])
                    - 4 * longint'(pres[i]);
                neg = lap < 0;
                mag = neg ? longint'(-lap) : longint'(lap);
                hi = mag >> 32;
                lo = mag & 64'hFFFFFFFF;
                t = ((hi * m_gain) << 16) + ((lo * m_gain) >> 16);
                f = fac[i];
                q = (t >> 16) * f + (((t & 64'hFFFF) * f) >> 16);
                if (q > (64'd1 << 33))
                    q = 64'd1 << 33;
                a = neg ? -longint'(q) : longint'(q);
                vel[i] = sat(longint'(vel[i]) + a);
            end
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                i = r * GRID_SIDE + c;
                v = vel[i];
                d = dep[i];
                cl = (d < longint'(m_dlim)) ? d : longint'(m_dlim);
                pp = mul_tz(pres[i], m_pret, 16);
                vv = mul_tz(mul_tz(v, m_stime, 32), fac[i], 16);
                pres[i] = sat(pp + vv + cl);
                dep[i] = sat(d - cl);
                vel[i] = sat(mul_tz(v, m_vret, 16));
            end
        end
    endfunction

    function automatic res_t field_apply(input logic [2:0] op, input logic [4:0] r,
                                         input logic [4:0] c, input logic [1:0] arr,
                                         input logic signed [31:0] val,
                                         input logic [15:0] rf, input logic [15:0] cf);
        res_t o;
        int n, i, r2, c2;
        longint a, b;
        o.val = '0;
        o.err = 1'b0;
        n = side_n();
        if (op == OP_STEP) begin
            advance_field();
            return o;
        end
        if (op > OP_SAMPLE)
            return o;
        if (r >= n || c >= n) begin
            o.err = 1'b1;
            return o;
        end
        i = r * GRID_SIDE + c;
        case (op)
            OP_WRITE:
                case (arr)
                    ARR_PRESSURE: pres[i] = val;
                    ARR_VELOCITY: vel[i] = val;
                    ARR_FACTOR:   fac[i] = (val < 0) ? 17'd0 :
                                           (val > 131071) ? FACTOR_MAX : val[16:0];
                    default:      dep[i] = val;
                endcase
            OP_ADD:
                dep[i] = sat(longint'(dep[i]) + longint'(val));
            OP_READ:
                case (arr)
                    ARR_PRESSURE: o.val = pres[i];
                    ARR_VELOCITY: o.val = vel[i];
                    ARR_FACTOR:   o.val = {15'd0, fac[i]};
                    default:      o.val = dep[i];
                endcase
            default: begin
                r2 = (r + 1) % n;
                c2 = (c + 1) % n;
                a = blend(pres[i], pres[r2 * GRID_SIDE + c], rf);
                b = blend(pres[r * GRID_SIDE + c2], pres[r2 * GRID_SIDE + c2], rf);
                o.val = sat(blend(a, b, cf));
            end
        endcase
        return o;
    endfunction

    // monitor: prediction on item transactions, checks on result transactions
    always @(posedge clk) begin
        res_t e;
        res_t want;
        if (rst_n) begin
            if (item_valid && !item_stall) begin
                e = field_apply(operation, row, col, which_array, value,
                                row_fraction, col_fraction);
                if (drv_typed) begin
                    e.val = drv_want_val;
                    e.err = drv_want_err;
                end
                pending_results.push_back(e);
                n_items++;
                if (operation == OP_STEP)
                    n_steps++;
                if (e.err)
                    n_bad_idx++;
            end
            if (result_valid && !result_stall) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result value=%0d index_error=%0b",
                             $time, result_value, index_error);
                end
                else begin
                    want = pending_results.pop_front();
                    if (result_value !== want.val) begin
                        errors++;
                        $display("%0t: result_value expected %0d actual %0d",
                                 $time, want.val, result_value);
                    end
                    if (index_error !== want.err) begin
                        errors++;
                        $display("%0t: index_error expected %0b actual %0b",
                                 $time, want.err, index_error);
                    end
                end
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= 60000) begin
                $display("%0t: watchdog expired", $time);
                $display("wave_field_2d_step_core verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACTIVE_SIZE:     m_size  = data[5:0];
            CFG_FORCE_GAIN:      m_gain  = data;
            CFG_STEP_TIME:       m_stime = data;
            CFG_PRESSURE_RETAIN: m_pret  = data[16:0];
            CFG_VELOCITY_RETAIN: m_vret  = data[16:0];
            default:             m_dlim  = data[30:0];
        endcase
    endtask

    task automatic send(input row_t it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        operation    <= it.op;
        row          <= it.r;
        col          <= it.c;
        which_array  <= it.arr;
        value        <= it.val;
        row_fraction <= it.rf;
        col_fraction <= it.cf;
        drv_typed    <= it.typed;
        drv_want_val <= it.want_val;
        drv_want_err <= it.want_err;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic row_t mk(input logic [2:0] op, input int r, input int c,
                                input logic [1:0] arr, input logic [31:0] val,
                                input int rf, input int cf, input bit typed,
                                input logic [31:0] wv, input logic we);
        row_t t;
        t.op = op; t.r = 5'(r); t.c = 5'(c); t.arr = arr; t.val = val;
        t.rf = 16'(rf); t.cf = 16'(cf); t.typed = typed; t.want_val = wv; t.want_err = we;
        return t;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            3: return $urandom_range(131071);
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    function automatic row_t rand_item(input int n, input bit allow_step);
        row_t t;
        int k;
        k = $urandom_range(99);
        if (allow_step && k < 14)
            t.op = OP_STEP;
        else if (k < 40)
            t.op = OP_WRITE;
        else if (k < 54)
            t.op = OP_ADD;
        else if (k < 74)
            t.op = OP_READ;
        else if (k < 95)
            t.op = OP_SAMPLE;
        else
            t.op = 3'($urandom_range(5, 7));
        if ($urandom_range(99) < 85) begin
            t.r = 5'($urandom_range(n - 1));
            t.c = 5'($urandom_range(n - 1));
        end
        else begin
            t.r = 5'($urandom_range(31));
            t.c = 5'($urandom_range(31));
        end
        t.arr = 2'($urandom_range(3));
        t.val = rand_value();
        t.rf = 16'($urandom_range(65535));
        t.cf = 16'($urandom_range(65535));
        t.typed = 1'b0;
        t.want_val = '0;
        t.want_err = 1'b0;
        return t;
    endfunction

    function automatic logic [31:0] pick(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return lo + 32'({$urandom, $urandom} % (64'(hi) - 64'(lo) + 64'd1));
        endcase
    endfunction

    initial begin
        int split;
        int n;
        int steps_here;
        int sizes[8];
        row_t it;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        operation = '0;
        row = '0;
        col = '0;
        which_array = '0;
        value = '0;
        row_fraction = '0;
        col_fraction = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        drv_typed = 1'b0;
        drv_want_val = '0;
        drv_want_err = 1'b0;
        errors = 0; n_items = 0; n_steps = 0; n_results = 0; n_bad_idx = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < CELLS; i++) begin
            pres[i] = '0;
            vel[i] = '0;
            dep[i] = '0;
            fac[i] = FACTOR_ONE;
        end
        m_size = 6'd32; m_gain = '0; m_stime = '0;
        m_pret = 17'd65536; m_vret = 17'd65536; m_dlim = '0;

        // directed table at reset settings
        directed.push_back(mk(OP_READ, 0, 0, ARR_PRESSURE, 0, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_READ, 31, 31, ARR_FACTOR, 0, 0, 0, 1, 65536, 0));
        directed.push_back(mk(OP_READ, 31, 0, ARR_VELOCITY, 0, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_WRITE, 0, 0, ARR_PRESSURE, 32'h7FFFFFFF, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_READ, 0, 0, ARR_PRESSURE, 0, 0, 0, 1, 32'h7FFFFFFF, 0));
        directed.push_back(mk(OP_WRITE, 1, 1, ARR_PRESSURE, 32'h80000000, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_READ, 1, 1, ARR_PRESSURE, 0, 0, 0, 1, 32'h80000000, 0));
        directed.push_back(mk(OP_WRITE, 2, 2, ARR_FACTOR, -5, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_READ, 2, 2, ARR_FACTOR, 0, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_WRITE, 2, 3, ARR_FACTOR, 200000, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_READ, 2, 3, ARR_FACTOR, 0, 0, 0, 1, 131071, 0));
        directed.push_back(mk(OP_WRITE, 3, 3, ARR_DEPOSIT, 32'h7FFFFFFF, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_ADD, 3, 3, ARR_PRESSURE, 100, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_READ, 3, 3, ARR_DEPOSIT, 0, 0, 0, 1, 32'h7FFFFFFF, 0));
        directed.push_back(mk(OP_ADD, 3, 4, ARR_PRESSURE, 32'h80000000, 0, 0, 0, 0, 0));
        directed.push_back(mk(OP_READ, 3, 4, ARR_DEPOSIT, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(3'd5, 7, 7, ARR_DEPOSIT, -1, 65535, 65535, 1, 0, 0));
        directed.push_back(mk(3'd7, 31, 31, ARR_DEPOSIT, -1, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_SAMPLE, 0, 0, ARR_PRESSURE, 0, 0, 0, 1, 32'h7FFFFFFF, 0));
        directed.push_back(mk(OP_SAMPLE, 31, 31, ARR_PRESSURE, 0, 65535, 65535, 0, 0, 0));
        directed.push_back(mk(OP_SAMPLE, 0, 31, ARR_PRESSURE, 0, 32768, 1, 0, 0, 0));
        directed.push_back(mk(OP_STEP, 31, 31, ARR_DEPOSIT, -1, 0, 0, 1, 0, 0));
        split = directed.size();
        // after shrinking the grid to 2x2
        directed.push_back(mk(OP_READ, 2, 0, ARR_PRESSURE, 0, 0, 0, 1, 0, 1));
        directed.push_back(mk(OP_SAMPLE, 0, 31, ARR_PRESSURE, 0, 0, 0, 1, 0, 1));
        directed.push_back(mk(OP_WRITE, 31, 31, ARR_PRESSURE, 9, 0, 0, 1, 0, 1));
        directed.push_back(mk(OP_SAMPLE, 1, 1, ARR_PRESSURE, 0, 40000, 20000, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < split; k++)
            send(directed[k]);
        drain();
        cfg_write(CFG_ACTIVE_SIZE, 0);
        for (int k = split; k < directed.size(); k++)
            send(directed[k]);
        drain();

        // random phases; steps on large grids are rationed
        sizes = '{4, 2, 8, 63, 6, 5, 16, 3};
        for (int p = 0; p < 8; p++) begin
            cfg_write(CFG_ACTIVE_SIZE, sizes[p]);
            cfg_write(CFG_FORCE_GAIN, pick(0, 32'hFFFFFFFF));
            cfg_write(CFG_STEP_TIME, pick(0, 32'hFFFFFFFF));
            cfg_write(CFG_PRESSURE_RETAIN, pick(0, 65536));
            cfg_write(CFG_VELOCITY_RETAIN, pick(0, 65536));
            cfg_write(CFG_DEPOSIT_LIMIT, pick(0, 32'h7FFFFFFF));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            n = side_n();
            steps_here = 0;
            for (int k = 0; k < 33; k++) begin
                it = rand_item(n, (n < 16) || (steps_here < 4));
                if (it.op == OP_STEP)
                    steps_here++;
                send(it);
                if (p == 2 && k == 18) begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("Covered %0d transactions (%0d steps, %0d index errors), %0d results checked,",
                 n_items, n_steps, n_bad_idx, n_results);
        $display("across grid sizes 2 to 32 with extreme and random register settings.");
        if (errors == 0)
            $display("wave_field_2d_step_core verification clean");
        else
            $display("wave_field_2d_step_core verification failed");
        $finish;
    end

endmodule
